FILE: rtl/ltc_pkg.sv
// Package: shared constants and types for the tile cache.
package ltc_pkg;

	localparam int CAPACITY_DEF    = 256;
	localparam int MAX_COARSER_DEF = 2;

	localparam logic [1:0] CMD_EXACT = 2'd0;
	localparam logic [1:0] CMD_BEST  = 2'd1;
	localparam logic [1:0] CMD_PUT   = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Slot record as stored in RAM: key, payload, stamp.
	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] so;
		logic [7:0]  lvl;
		logic [31:0] hash;
		logic [31:0] handle;
		logic [7:0]  blevel;
		logic [63:0] stamp;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: rtl/ltc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ltc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/lru_tile_cache_coarser_fallback_core.sv
// Top level: fully associative LRU tile cache with coarser-level fallback.
// Sequence: a pass reads the n slots in order; a hit ends its pass early. The passes are
//   followed by done, output and idle: exact and put make one pass, best lookup up to
//   MAX_COARSER+1 passes. Clear goes straight from idle to output.
// Throughput: one transaction at a time; a result may wait in the output register.
// Reset: arst_n clears valid bits, the use clock (to 1), config (to 256) and control.
module lru_tile_cache_coarser_fallback_core #(
	parameter int CAPACITY    = ltc_pkg::CAPACITY_DEF,
	parameter int MAX_COARSER = ltc_pkg::MAX_COARSER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write channel: entries_in_use
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [8:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] command, [17:2] tile_col, [33:18] tile_row, [49:34] scale_code,
	// [65:50] offset_code, [73:66] key_level, [105:74] param_hash,
	// [137:106] buffer_handle, [145:138] buffer_level, [151:146] zero
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] hit, [32:1] found_handle, [40:33] found_level,
	// [41] released_valid, [73:42] released_handle, [79:74] zero
	output logic [79:0]  m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = $clog2(MAX_COARSER + 2);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DONE  = 3'd2;
	localparam logic [2:0] ST_OUT   = 3'd3;

	logic [2:0]  state_q;
	logic [8:0]  cfg_q;
	logic [63:0] clock_q;
	logic [CAPACITY-1:0] valid_q;

	// latched transaction
	logic [1:0]  cmd_q;
	logic [31:0] pos_q, so_q, hash_q, handle_q;
	logic [7:0]  lvl_q, blevel_q;
	logic [DW-1:0] try_q;

	// scan bookkeeping
	logic [CW-1:0] raddr_q;   // next address to issue
	logic [CW-1:0] cmp_q;     // address whose data is on rdata
	logic          cmp_v_q;   // rdata is live
	logic          match_q;
	logic [AW-1:0] match_idx_q;
	ltc_pkg::slot_t match_rec_q;
	logic          empty_q;
	logic [AW-1:0] empty_idx_q;
	logic          old_have_q;
	logic [AW-1:0] old_idx_q;
	ltc_pkg::slot_t old_rec_q;

	logic [79:0]   out_q;

	// RAM
	localparam int SLOT_W_LOC = ltc_pkg::SLOT_W;
	logic          we;
	logic [AW-1:0] waddr;
	ltc_pkg::slot_t wrec, rrec;
	logic [SLOT_W_LOC-1:0] rraw;

	ltc_ram #(.WIDTH(SLOT_W_LOC), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wrec),
		.raddr(raddr_q[AW-1:0]),
		.rdata(rraw)
	);
	assign rrec = ltc_pkg::slot_t'(rraw);

	// scan length: 0 or above capacity means all slots
	logic [CW-1:0] scan_n;
	always_comb begin
		if (cfg_q == 9'd0 || {23'd0, cfg_q} > CAPACITY) begin
			scan_n = CW'(CAPACITY);
		end else begin
			scan_n = CW'(cfg_q);
		end
	end

	logic [7:0] try_lvl;
	assign try_lvl = lvl_q + 8'(try_q);

	logic cmp_valid_slot, cmp_hit;
	assign cmp_valid_slot = cmp_v_q && valid_q[cmp_q[AW-1:0]];
	assign cmp_hit = cmp_valid_slot && rrec.pos == pos_q && rrec.so == so_q &&
		rrec.lvl == try_lvl && rrec.hash == hash_q;

	logic [DW-1:0] tries;
	assign tries = (cmd_q == ltc_pkg::CMD_EXACT || cmd_q == ltc_pkg::CMD_PUT) ?
		DW'(1) : DW'(MAX_COARSER + 1);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = out_q;

	// write port set in ST_DONE
	ltc_pkg::slot_t put_rec;
	logic [AW-1:0] put_idx;
	logic          put_release;
	logic [31:0]   rel_handle;
	always_comb begin
		put_idx = match_idx_q;
		put_rec = match_rec_q;
		put_release = 1'b0;
		rel_handle = 32'd0;
		if (match_q) begin
			put_release = 1'b1;
			rel_handle = match_rec_q.handle;
		end else if (empty_q) begin
			put_idx = empty_idx_q;
			put_rec.pos = pos_q;
			put_rec.so = so_q;
			put_rec.lvl = lvl_q;
			put_rec.hash = hash_q;
		end else begin
			put_idx = old_idx_q;
			put_rec.pos = pos_q;
			put_rec.so = so_q;
			put_rec.lvl = lvl_q;
			put_rec.hash = hash_q;
			put_release = 1'b1;
			rel_handle = old_rec_q.handle;
		end
		put_rec.handle = handle_q;
		put_rec.blevel = blevel_q;
		put_rec.stamp = clock_q;
	end

	always_comb begin
		we = 1'b0;
		waddr = put_idx;
		wrec = put_rec;
		if (state_q == ST_DONE && match_q && cmd_q != ltc_pkg::CMD_PUT) begin
			we = 1'b1;
			wrec = match_rec_q;
			wrec.stamp = clock_q;
		end else if (state_q == ST_DONE && cmd_q == ltc_pkg::CMD_PUT) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q <= 9'd256;
			clock_q <= 64'd1;
			valid_q <= '0;
			cmp_v_q <= 1'b0;
			raddr_q <= '0;
			try_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						cfg_q <= cfg_data;
					end
					if (s_tvalid) begin
						if (s_tdata[1:0] == ltc_pkg::CMD_CLEAR) begin
							valid_q <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
						raddr_q <= '0;
						cmp_v_q <= 1'b0;
						try_q <= '0;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, compare its data in the cycle after
					if (raddr_q < scan_n) begin
						raddr_q <= raddr_q + CW'(1);
						cmp_v_q <= 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
					end
					cmp_q <= raddr_q;
					if (cmp_hit && !match_q) begin
						// first match ends the pass early
						state_q <= ST_DONE;
						cmp_v_q <= 1'b0;
					end else if (cmp_v_q && cmp_q == scan_n - CW'(1)) begin
						if (try_q + DW'(1) < tries && cmd_q != ltc_pkg::CMD_PUT) begin
							try_q <= try_q + DW'(1);
							raddr_q <= '0;
							cmp_v_q <= 1'b0;
						end else begin
							state_q <= ST_DONE;
							cmp_v_q <= 1'b0;
						end
					end
				end
				ST_DONE: begin
					if (match_q || cmd_q == ltc_pkg::CMD_PUT) begin
						clock_q <= clock_q + 64'd1;
					end
					if (cmd_q == ltc_pkg::CMD_PUT) begin
						valid_q[put_idx] <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and scan results
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= s_tdata[1:0];
				pos_q    <= {s_tdata[17:2], s_tdata[33:18]};
				so_q     <= {s_tdata[49:34], s_tdata[65:50]};
				lvl_q    <= s_tdata[73:66];
				hash_q   <= s_tdata[105:74];
				handle_q <= s_tdata[137:106];
				blevel_q <= s_tdata[145:138];
				match_q <= 1'b0;
				empty_q <= 1'b0;
				old_have_q <= 1'b0;
				out_q <= '0;
			end
			ST_SCAN: begin
				if (cmp_hit && !match_q) begin
					match_q <= 1'b1;
					match_idx_q <= cmp_q[AW-1:0];
					match_rec_q <= rrec;
				end
				if (cmp_v_q && !cmp_valid_slot && !empty_q) begin
					empty_q <= 1'b1;
					empty_idx_q <= cmp_q[AW-1:0];
				end
				if (cmp_valid_slot && !empty_q &&
					(!old_have_q || rrec.stamp < old_rec_q.stamp)) begin
					old_have_q <= 1'b1;
					old_idx_q <= cmp_q[AW-1:0];
					old_rec_q <= rrec;
				end
			end
			ST_DONE: begin
				if (cmd_q == ltc_pkg::CMD_PUT) begin
					out_q <= {6'd0, rel_handle, put_release, 41'd0};
				end else if (match_q) begin
					out_q <= {6'd0, 32'd0, 1'b0, match_rec_q.blevel,
						match_rec_q.handle, 1'b1};
				end
			end
			default: ;
		endcase
	end

endmodule
